FILE: design/tkst_pkg.sv
// Package for the top-k sorted score table: beat types, action codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package tkst_pkg;

	localparam int MAX_ENTRIES_DEF = 10;
	localparam int MAX_ENTRIES_LIM = 64;

	localparam int SCORE_W = 32;
	localparam int TAG_W   = 24;
	localparam int INDEX_W = 6;
	localparam int RANK_W  = 7;

	localparam logic [1:0] ACT_CHECK  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [SCORE_W-1:0] score;
		logic [TAG_W-1:0]          tag;
		logic [INDEX_W-1:0]        index;
	} req_t;

	typedef struct packed {
		logic                      qualifies;
		logic [RANK_W-1:0]         placed_rank;
		logic                      read_valid;
		logic signed [SCORE_W-1:0] read_score;
		logic [TAG_W-1:0]          read_tag;
		logic [RANK_W-1:0]         entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_SCAN_CMP,
		ST_SHIFT,
		ST_SHIFT_WR,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic load;      // capture request beat
		logic rd_item;   // read entry named by the request (last slot for check)
		logic rd_scan;   // read entry at ptr
		logic rd_prev;   // read entry at ptr-1
		logic ptr_clr;
		logic ptr_inc;
		logic ptr_dec;
		logic ptr_last;  // ptr <= last slot to fill
		logic pos_take;  // pos <= ptr
		logic pos_count; // pos <= count
		logic mv_wr;     // entry[ptr] <= read data
		logic put_wr;    // entry[pos] <= new pair, grow count if not full
		logic finish;    // form and strobe result
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       scan_end;  // ptr == count
		logic       above;     // new score > read score
		logic       full;      // count == MAX_ENTRIES
		logic       shift_end; // ptr == pos
	} dp_sts_t;

endpackage

FILE: design/tkst_dp.sv
// Datapath of the top-k sorted score table: request and result registers,
// entry memory with registered read, scan/shift pointer, rank and count.
// Depends on tkst_pkg.
module tkst_dp import tkst_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    done,
	output rsp_t    rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] LAST_C = CW'(MAX_ENTRIES - 1);

	logic signed [SCORE_W-1:0] score_mem [MAX_ENTRIES];
	logic [TAG_W-1:0]          tag_mem   [MAX_ENTRIES];

	req_t                      req_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             ptr_q;
	logic [CW-1:0]             pos_q;
	logic signed [SCORE_W-1:0] rd_score_q;
	logic [TAG_W-1:0]          rd_tag_q;
	logic                      done_q;
	rsp_t                      rsp_q;

	logic                      full;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             item_addr;
	logic [CW-1:0]             ptr_m1;
	logic                      idx_ok;
	logic                      qual;
	logic                      rv;

	assign full   = (count_q == MAX_C);
	assign ptr_m1 = ptr_q - CW'(1);
	assign idx_ok = ({1'b0, req_q.index} < RANK_W'(count_q));

	always_comb begin
		if (req_q.action == ACT_CHECK) begin
			item_addr = LAST_C[AW-1:0];
		end else if ({1'b0, req_q.index} < RANK_W'(MAX_ENTRIES)) begin
			item_addr = req_q.index[AW-1:0];
		end else begin
			item_addr = '0;
		end
	end

	always_comb begin
		rd_en = cmd.rd_item | cmd.rd_scan | cmd.rd_prev;
		priority if (cmd.rd_item) begin
			rd_addr = item_addr;
		end else if (cmd.rd_prev) begin
			rd_addr = ptr_m1[AW-1:0];
		end else begin
			rd_addr = ptr_q[AW-1:0];
		end
	end

	assign sts.action    = req_q.action;
	assign sts.scan_end  = (ptr_q == count_q);
	assign sts.above     = (req_q.score > rd_score_q);
	assign sts.full      = full;
	assign sts.shift_end = (ptr_q == pos_q);

	// entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.put_wr) begin
			score_mem[pos_q[AW-1:0]] <= req_q.score;
			tag_mem[pos_q[AW-1:0]]   <= req_q.tag;
		end else if (cmd.mv_wr) begin
			score_mem[ptr_q[AW-1:0]] <= rd_score_q;
			tag_mem[ptr_q[AW-1:0]]   <= rd_tag_q;
		end
		if (rd_en) begin
			rd_score_q <= score_mem[rd_addr];
			rd_tag_q   <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.put_wr && !full) begin
				count_q <= count_q + CW'(1);
			end
			priority if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_last) begin
				ptr_q <= full ? LAST_C : count_q;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_m1;
			end
			priority if (cmd.pos_take) begin
				pos_q <= ptr_q;
			end else if (cmd.pos_count) begin
				pos_q <= count_q;
			end
		end
	end

	assign qual = (req_q.action == ACT_CHECK) && !req_q.score[SCORE_W-1] &&
		(req_q.score != '0) && (!full || (req_q.score > rd_score_q));
	assign rv   = (req_q.action == ACT_READ) && idx_ok;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.qualifies   <= qual;
			rsp_q.placed_rank <= (req_q.action == ACT_INSERT) ? RANK_W'(pos_q) : '0;
			rsp_q.read_valid  <= rv;
			rsp_q.read_score  <= rv ? rd_score_q : '0;
			rsp_q.read_tag    <= rv ? rd_tag_q : '0;
			rsp_q.entry_count <= RANK_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: design/tkst_ctl.sv
// Controller of the top-k sorted score table: sequences lookup, scan,
// shift and place steps over the datapath.
// Depends on tkst_pkg.
module tkst_ctl import tkst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output logic    busy,
	output dp_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = (sts.action == ACT_INSERT) ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (!sts.scan_end) begin
					state_d = ST_SCAN_CMP;
				end else if (sts.full) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SCAN_CMP: begin
				state_d = sts.above ? ST_SHIFT : ST_SCAN;
			end
			ST_SHIFT: begin
				state_d = sts.shift_end ? ST_FINISH : ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				state_d = ST_SHIFT;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_LOOKUP: begin
				cmd.rd_item = (sts.action != ACT_INSERT);
				cmd.ptr_clr = (sts.action == ACT_INSERT);
			end
			ST_SCAN: begin
				if (!sts.scan_end) begin
					cmd.rd_scan = 1'b1;
				end else begin
					cmd.pos_count = 1'b1;
					cmd.ptr_last  = !sts.full;
				end
			end
			ST_SCAN_CMP: begin
				if (sts.above) begin
					cmd.pos_take = 1'b1;
					cmd.ptr_last = 1'b1;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_end) begin
					cmd.put_wr = 1'b1;
				end else begin
					cmd.rd_prev = 1'b1;
				end
			end
			ST_SHIFT_WR: begin
				cmd.mv_wr   = 1'b1;
				cmd.ptr_dec = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/top_k_sorted_score_table.sv
// Top level of the top-k sorted score table: controller plus datapath.
// Depends on tkst_pkg, tkst_ctl, tkst_dp.
//
// Usage:
//   A request beat (req: action, score, tag, index) is taken at a rising
//   edge where start is high and busy is low. Action 0 checks whether a
//   score would enter the table, 1 inserts a (score, tag) pair in descending
//   order behind equal scores, 2 reads the entry at a rank; 3 does nothing.
//   Exactly one result beat follows per request: rsp is shown for one
//   cycle with done high, and the receiver cannot stall it.
//   Check, read and no-op pass the lookup and finish states before the
//   registered done. Insert walks the entry memory one word per step over
//   its single registered read port: a scan and a compare state per entry
//   scanned before the landing rank, a shift and a write state per entry moved
//   down, then the finish state. busy stays high for the whole request;
//   the next request may be taken in the cycle that done is shown.
//   Reset empties the table (count to zero); entry storage is not cleared
//   and needs no clearing pass, entries at or beyond the count never reach
//   the result.
module top_k_sorted_score_table import tkst_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tkst_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	tkst_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

FILE: bench/tkst_score_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k sorted score table: keeps a shadow ranking, predicts each result
// beat from the accepted request beats and compares it field by field. Depends on tkst_pkg.
module tkst_score_checker import tkst_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fails,
	output int   pending,
	output int   drops,
	output int   results
);

	logic signed [SCORE_W-1:0] kept_score [MAX_ENTRIES];
	logic [TAG_W-1:0]          kept_tag   [MAX_ENTRIES];
	int                        kept_cnt;
	rsp_t                      due_rsp [$];

	function automatic rsp_t ranking_step(req_t r);
		rsp_t o;
		logic signed [SCORE_W-1:0] s;
		int pos;
		int last;
		o = '0;
		s = r.score;
		unique case (r.action)
			ACT_CHECK: begin
				o.qualifies = (s > 0) &&
					(kept_cnt < MAX_ENTRIES || s > kept_score[MAX_ENTRIES-1]);
			end
			ACT_INSERT: begin
				pos = 0;
				while (pos < kept_cnt && !(s > kept_score[pos]))
					pos++;
				if (pos >= MAX_ENTRIES) begin
					o.placed_rank = RANK_W'(MAX_ENTRIES);
					drops++;
				end else begin
					last = (kept_cnt < MAX_ENTRIES) ? kept_cnt : MAX_ENTRIES - 1;
					for (int i = last; i > pos; i--) begin
						kept_score[i] = kept_score[i-1];
						kept_tag[i]   = kept_tag[i-1];
					end
					kept_score[pos] = s;
					kept_tag[pos]   = r.tag;
					if (kept_cnt < MAX_ENTRIES)
						kept_cnt++;
					o.placed_rank = RANK_W'(pos);
				end
			end
			ACT_READ: begin
				if (r.index < kept_cnt) begin
					o.read_valid = 1'b1;
					o.read_score = kept_score[r.index];
					o.read_tag   = kept_tag[r.index];
				end
			end
			default: ;
		endcase
		o.entry_count = RANK_W'(kept_cnt);
		return o;
	endfunction

	task automatic flag(string why, rsp_t want, rsp_t got);
		fails++;
		if (fails <= 10) begin
			$display("%0t %s: exp q=%0d rank=%0d rv=%0d score=%0d tag=%06h cnt=%0d",
				$time, why,
				want.qualifies, want.placed_rank, want.read_valid, want.read_score,
				want.read_tag, want.entry_count);
			$display("%0t %s: got q=%0d rank=%0d rv=%0d score=%0d tag=%06h cnt=%0d",
				$time, why,
				got.qualifies, got.placed_rank, got.read_valid, got.read_score,
				got.read_tag, got.entry_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			kept_cnt = 0;
			due_rsp.delete();
			fails   = 0;
			pending = 0;
			drops   = 0;
			results = 0;
		end else begin
			if (done === 1'b1) begin
				results++;
				if (due_rsp.size() == 0) begin
					flag("result beat with nothing pending", '0, rsp);
				end else begin
					want = due_rsp.pop_front();
					if (rsp.qualifies !== want.qualifies ||
					    rsp.placed_rank !== want.placed_rank ||
					    rsp.read_valid !== want.read_valid ||
					    rsp.read_score !== want.read_score ||
					    rsp.read_tag !== want.read_tag ||
					    rsp.entry_count !== want.entry_count)
						flag("result mismatch", want, rsp);
				end
			end else if (done !== 1'b0) begin
				flag("done unknown", '0, rsp);
			end
			if (start === 1'b1 && busy === 1'b0)
				due_rsp.insert(due_rsp.size(), ranking_step(req));
			pending = due_rsp.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for the top-k sorted score table: drives directed and random request beats
// with sender gaps and gives the verdict. Depends on tkst_pkg and tkst_score_checker.
module tb;
	import tkst_pkg::*;

	localparam int         N_RANDOM   = 1425;
	localparam int         DRAIN      = 2 * MAX_ENTRIES_DEF + 8;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;
	int   fails;
	int   pending;
	int   drops;
	int   results;
	int   sent [4];
	int   idle_pct;

	top_k_sorted_score_table #(.MAX_ENTRIES(MAX_ENTRIES_DEF)) u_top (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp
	);

	tkst_score_checker #(.MAX_ENTRIES(MAX_ENTRIES_DEF)) u_chk (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.fails, .pending, .drops, .results
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic req_t beat(logic [1:0] act, logic [31:0] s, logic [23:0] t,
		logic [5:0] idx);
		req_t r;
		r.action = act;
		r.score  = s;
		r.tag    = t;
		r.index  = idx;
		return r;
	endfunction

	// rising base keeps inserts landing once the table is full; coarse steps give ties
	function automatic logic [31:0] pick_score(int k, logic [1:0] act);
		int unsigned r;
		logic [31:0] s;
		r = $urandom_range(99);
		if (r < 60)
			s = (k * 1400000 + $urandom_range(8000000)) & 32'hFFF0_0000;
		else if (r < 75)
			s = $urandom_range(24) - 4;
		else if (r < 94)
			s = $urandom;
		else begin
			case ($urandom_range(4))
				0: s = 32'h8000_0000;
				1: s = '0;
				2: s = 32'd1;
				3: s = '1;
				default: s = (act == ACT_CHECK) ? 32'h7FFF_FFFF : 32'd2;
			endcase
		end
		return s;
	endfunction

	function automatic req_t rand_beat(int k);
		int unsigned r;
		logic [1:0] act;
		logic [5:0] idx;
		r = $urandom_range(99);
		act = (r < 45) ? ACT_INSERT : (r < 75) ? ACT_READ : (r < 95) ? ACT_CHECK : ACT_UNUSED;
		r = $urandom_range(99);
		idx = (r < 70) ? 6'($urandom_range(9)) :
			(r < 85) ? 6'($urandom_range(12, 10)) : 6'($urandom);
		return beat(act, pick_score(k, act), 24'($urandom), idx);
	endfunction

	task automatic send(input req_t r);
		int gap;
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(30, 1);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sent[r.action]++;
	endtask

	initial begin
		int k;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		idle_pct = 0;
		foreach (sent[i]) sent[i] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty table
		send(beat(ACT_READ,   32'd0,        24'h000000, 6'd0));
		send(beat(ACT_CHECK,  32'd1,        24'h000000, 6'd0));
		send(beat(ACT_CHECK,  32'd0,        24'h000000, 6'd0));
		send(beat(ACT_CHECK,  32'h8000_0000, 24'h000000, 6'd0));
		send(beat(ACT_UNUSED, 32'hFFFF_FFFF, 24'hFFFFFF, 6'd63));
		// fill, with non-positive scores and ties
		send(beat(ACT_INSERT, -32'sd5,      24'h414141, 6'd0));
		send(beat(ACT_INSERT, 32'd0,        24'h424242, 6'd63));
		send(beat(ACT_INSERT, 32'h8000_0000, 24'h000000, 6'd0));
		send(beat(ACT_INSERT, 32'h7FFF_FFFF, 24'hFFFFFF, 6'd0));
		send(beat(ACT_INSERT, 32'd7,        24'h000001, 6'd0));
		send(beat(ACT_INSERT, 32'd7,        24'h000002, 6'd0));
		send(beat(ACT_INSERT, 32'd3,        24'h434343, 6'd0));
		send(beat(ACT_INSERT, 32'd12,       24'h444444, 6'd0));
		send(beat(ACT_INSERT, 32'd7,        24'h000003, 6'd0));
		send(beat(ACT_INSERT, 32'd2,        24'h454545, 6'd0));
		// full table
		send(beat(ACT_CHECK,  -32'sd1,      24'h000000, 6'd0));
		send(beat(ACT_CHECK,  32'd1,        24'h000000, 6'd0));
		send(beat(ACT_INSERT, 32'h8000_0000, 24'h464646, 6'd0));
		send(beat(ACT_INSERT, 32'd1,        24'h474747, 6'd0));
		send(beat(ACT_INSERT, -32'sd5,      24'h484848, 6'd0));
		send(beat(ACT_CHECK,  -32'sd5,      24'h000000, 6'd0));
		send(beat(ACT_CHECK,  32'd0,        24'h000000, 6'd0));
		send(beat(ACT_READ,   32'd0,        24'h000000, 6'd9));
		send(beat(ACT_READ,   32'd0,        24'h000000, 6'd10));
		send(beat(ACT_READ,   32'd0,        24'h000000, 6'd63));
		for (int i = 1; i <= 3; i++)
			send(beat(ACT_READ, 32'd0, 24'h000000, 6'(i)));

		k = 0;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 27 : (ph == 1) ? 63 : 0;
			repeat (N_RANDOM / 3) begin
				send(rand_beat(k));
				k++;
			end
		end

		@(negedge clk) start <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN) @(posedge clk);
		$display("%0d result beats: %0d checks, %0d inserts (%0d dropped), %0d reads, %0d unused",
			results, sent[ACT_CHECK], sent[ACT_INSERT], drops, sent[ACT_READ],
			sent[ACT_UNUSED]);
		$display("sender gaps in 27%%, then 63%%, then back to back; %0d mismatches", fails);
		if (fails == 0 && pending == 0)
			$display("[top_k_sorted_score_table] OK");
		else
			$display("[top_k_sorted_score_table] ERROR");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("[top_k_sorted_score_table] ERROR");
		$finish;
	end

endmodule
